FILE: sv/v3n_pkg.sv
// package: payload types and constants for the 3d vector normalizer
`timescale 1ns / 1ps
`default_nettype none
package v3n_pkg;

	localparam int CompW   = 16;
	localparam int SqW     = 31;
	localparam int SumW    = 32;
	localparam int RemW    = 33;
	localparam int QuoW    = 29;
	localparam int MagW    = 15;
	localparam int LenW    = 16;
	localparam int DivSteps  = QuoW;
	localparam int RootSteps = MagW;
	localparam int LenSteps  = LenW;
	localparam int ChainLen  = DivSteps + RootSteps;

	localparam logic [CompW-1:0] UnitOne = 16'd16384;
	localparam logic [LenW-1:0]  LenOne  = 16'd256;

	typedef struct packed {
		logic signed [CompW-1:0] x_in;
		logic signed [CompW-1:0] y_in;
		logic signed [CompW-1:0] z_in;
	} vec_in_t;

	typedef struct packed {
		logic signed [CompW-1:0] unit_x;
		logic signed [CompW-1:0] unit_y;
		logic signed [CompW-1:0] unit_z;
		logic [LenW-1:0]         length_out;
	} vec_out_t;

	typedef struct packed {
		logic       zero;
		logic [2:0] neg;
	} flags_t;

endpackage
`default_nettype wire

FILE: sv/v3n_div_cell.sv
// one restoring division step producing quotient bit B
`timescale 1ns / 1ps
`default_nettype none
module v3n_div_cell import v3n_pkg::*; #(
	parameter int B = 0
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [RemW-1:0] rem_i,
	input  wire logic [SumW-1:0] den_i,
	input  wire logic [QuoW-1:0] quo_i,
	output logic [RemW-1:0]      rem_q,
	output logic [QuoW-1:0]      quo_q
);

	logic            ge;
	logic [RemW-1:0] diff;

	always_comb begin
		ge   = rem_i >= {1'b0, den_i};
		diff = ge ? (rem_i - {1'b0, den_i}) : rem_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// remainder stays below the divisor, so the shift cannot overflow
			rem_q <= {diff[RemW-2:0], 1'b0};
			quo_q <= quo_i | (QuoW'(ge) << B);
		end
	end

endmodule
`default_nettype wire

FILE: sv/v3n_sqrt_cell.sv
// one restoring square root step deciding root bit B
`timescale 1ns / 1ps
`default_nettype none
module v3n_sqrt_cell import v3n_pkg::*; #(
	parameter int W  = 32,
	parameter int RW = 16,
	parameter int B  = 0
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [W-1:0]  rem_i,
	input  wire logic [RW-1:0] root_i,
	output logic [W-1:0]       rem_q,
	output logic [RW-1:0]      root_q
);

	localparam int TW = W + 2;

	logic [TW-1:0] trial;
	logic          take;

	always_comb begin
		// (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
		trial = (TW'(root_i) << (B + 1)) + (TW'(1) << (2 * B));
		take  = TW'(rem_i) >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= take ? W'(TW'(rem_i) - trial) : rem_i;
			root_q <= root_i | (RW'(take) << B);
		end
	end

endmodule
`default_nettype wire

FILE: sv/vector3_normalize.sv
// top level: pipelined 3d vector normalizer built from a chain of arithmetic cells
//
//   channel | signals                       | payload
//   --------+-------------------------------+--------------------------------------
//   input   | in_valid, in_ready, in_data   | x_in, y_in, z_in (signed q8.8)
//   output  | out_valid, out_ready, out_data| unit_x/y/z (signed q1.14), length_out
//
// one transaction accepted per cycle while the output side keeps up
// data passes the input register, squares and sum, 29 division cells,
// 15 square root cells and the output register
// the whole chain advances together; it holds when the output register is full
// and out_ready is low, and in_ready follows that same enable
// reset clears only the valid bits; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module vector3_normalize import v3n_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire vec_in_t  in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output vec_out_t      out_data
);

	// chain enable shared by every stage
	logic en;

	// stage 1: captured input
	vec_in_t in_s1;
	logic    v_s1;

	// stage 2: squares, sum of squares, flags
	logic [SqW-1:0]  asq_s2 [3];
	logic [SumW-1:0] sum_s2;
	flags_t          flags_s2;
	logic            v_s2;

	// cell chain side registers
	logic            vc_q   [ChainLen];
	flags_t          fl_q   [ChainLen];
	logic [SumW-1:0] sum_q  [DivSteps];
	logic [LenW-1:0] len_q  [LenSteps:ChainLen-1];

	// division lanes: q = floor(a^2 * 2^28 / S)
	logic [RemW-1:0] drem_q [3][DivSteps];
	logic [QuoW-1:0] dquo_q [3][DivSteps];
	// unit square root lanes: mag = floor(sqrt(q))
	logic [QuoW-1:0] urem_q [3][RootSteps];
	logic [MagW-1:0] uroot_q[3][RootSteps];
	// length square root
	logic [SumW-1:0] lrem_q [LenSteps];
	logic [LenW-1:0] lroot_q[LenSteps];

	vec_out_t out_q;
	logic     out_valid_q;

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// input register and the square/sum stage
	logic signed [2*CompW-1:0] px, py, pz;

	always_comb begin
		px = in_s1.x_in * in_s1.x_in;
		py = in_s1.y_in * in_s1.y_in;
		pz = in_s1.z_in * in_s1.z_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1     <= in_data;
			asq_s2[0] <= px[SqW-1:0];
			asq_s2[1] <= py[SqW-1:0];
			asq_s2[2] <= pz[SqW-1:0];
			sum_s2    <= SumW'(px[SqW-1:0]) + SumW'(py[SqW-1:0]) + SumW'(pz[SqW-1:0]);
			flags_s2.zero <= (in_s1.x_in == '0) && (in_s1.y_in == '0) &&
				(in_s1.z_in == '0);
			flags_s2.neg  <= {in_s1.x_in[CompW-1], in_s1.y_in[CompW-1],
				in_s1.z_in[CompW-1]};
		end
	end

	// valid bits and side data marching alongside the cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < ChainLen; i++) begin
				vc_q[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			vc_q[0]     <= v_s2;
			for (int i = 1; i < ChainLen; i++) begin
				vc_q[i] <= vc_q[i-1];
			end
			out_valid_q <= vc_q[ChainLen-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_q[0]  <= flags_s2;
			sum_q[0] <= sum_s2;
			for (int i = 1; i < ChainLen; i++) begin
				fl_q[i] <= fl_q[i-1];
			end
			for (int i = 1; i < DivSteps; i++) begin
				sum_q[i] <= sum_q[i-1];
			end
			// length root is final after its last cell, then just rides along
			len_q[LenSteps] <= lroot_q[LenSteps-1];
			for (int i = LenSteps + 1; i < ChainLen; i++) begin
				len_q[i] <= len_q[i-1];
			end
		end
	end

	genvar l, c;
	generate
		for (l = 0; l < 3; l++) begin : g_lane
			// division cells, quotient bit 28 first
			for (c = 0; c < DivSteps; c++) begin : g_div
				logic [RemW-1:0] rem_in;
				logic [SumW-1:0] den_in;
				logic [QuoW-1:0] quo_in;
				if (c == 0) begin : g_first
					assign rem_in = RemW'(asq_s2[l]);
					assign den_in = sum_s2;
					assign quo_in = '0;
				end else begin : g_next
					assign rem_in = drem_q[l][c-1];
					assign den_in = sum_q[c-1];
					assign quo_in = dquo_q[l][c-1];
				end
				v3n_div_cell #(.B(DivSteps - 1 - c)) u_div (
					.clk   (clk),
					.en    (en),
					.rem_i (rem_in),
					.den_i (den_in),
					.quo_i (quo_in),
					.rem_q (drem_q[l][c]),
					.quo_q (dquo_q[l][c])
				);
			end
			// square root cells on the quotient, root bit 14 first
			for (c = 0; c < RootSteps; c++) begin : g_root
				logic [QuoW-1:0] rem_in;
				logic [MagW-1:0] root_in;
				if (c == 0) begin : g_first
					assign rem_in  = dquo_q[l][DivSteps-1];
					assign root_in = '0;
				end else begin : g_next
					assign rem_in  = urem_q[l][c-1];
					assign root_in = uroot_q[l][c-1];
				end
				v3n_sqrt_cell #(.W(QuoW), .RW(MagW), .B(RootSteps - 1 - c)) u_root (
					.clk    (clk),
					.en     (en),
					.rem_i  (rem_in),
					.root_i (root_in),
					.rem_q  (urem_q[l][c]),
					.root_q (uroot_q[l][c])
				);
			end
		end

		// length root runs beside the first division cells
		for (c = 0; c < LenSteps; c++) begin : g_len
			logic [SumW-1:0] rem_in;
			logic [LenW-1:0] root_in;
			if (c == 0) begin : g_first
				assign rem_in  = sum_s2;
				assign root_in = '0;
			end else begin : g_next
				assign rem_in  = lrem_q[c-1];
				assign root_in = lroot_q[c-1];
			end
			v3n_sqrt_cell #(.W(SumW), .RW(LenW), .B(LenSteps - 1 - c)) u_len (
				.clk    (clk),
				.en     (en),
				.rem_i  (rem_in),
				.root_i (root_in),
				.rem_q  (lrem_q[c]),
				.root_q (lroot_q[c])
			);
		end
	endgenerate

	// sign restore and zero-vector substitution
	logic [CompW-1:0] unit [3];
	flags_t           fl_last;

	always_comb begin
		fl_last = fl_q[ChainLen-1];
		for (int i = 0; i < 3; i++) begin
			unit[i] = fl_last.neg[2-i]
				? CompW'(CompW'(0) - CompW'(uroot_q[i][RootSteps-1]))
				: CompW'(uroot_q[i][RootSteps-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (fl_last.zero) begin
				out_q.unit_x     <= '0;
				out_q.unit_y     <= '0;
				out_q.unit_z     <= UnitOne;
				out_q.length_out <= LenOne;
			end else begin
				out_q.unit_x     <= unit[0];
				out_q.unit_y     <= unit[1];
				out_q.unit_z     <= unit[2];
				out_q.length_out <= len_q[ChainLen-1];
			end
		end
	end

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// testbench for the 3d vector normalizer: directed table, then random vectors vs predictor
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import v3n_pkg::*;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	vec_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	vec_out_t out_data;

	vector3_normalize dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// one directed row: input plus an optional typed-in answer
	typedef struct {
		vec_in_t  vec;
		bit       known;
		vec_out_t res;
	} row_t;

	vec_out_t expected_units[$];
	int       error_count = 0;
	int       send_idle_pct = 28;
	int       recv_idle_pct = 57;
	bit       sending_done = 1'b0;

	// floor square root of the squared length
	function automatic logic [15:0] length_floor(logic [33:0] sumsq);
		logic [17:0] r;
		logic [17:0] t;
		r = '0;
		for (int b = 17; b >= 0; b--) begin
			t = r | (18'd1 << b);
			if (36'(t) * 36'(t) <= 36'(sumsq))
				r = t;
		end
		return r[15:0];
	endfunction

	// largest q <= 16384 with q*q*s <= a*a*2^28
	function automatic logic [15:0] unit_component(logic signed [15:0] c, logic [33:0] sumsq);
		logic [15:0]  mag;
		logic [16:0]  a;
		logic [15:0]  q;
		logic [15:0]  t;
		logic [127:0] lhs;
		logic [127:0] rhs;
		a = (c < 0) ? 17'(-int'(c)) : 17'(c);
		rhs = (128'(a) * 128'(a)) << 28;
		q = '0;
		for (int b = 14; b >= 0; b--) begin
			t = q | (16'd1 << b);
			lhs = 128'(t) * 128'(t) * 128'(sumsq);
			if (t <= UnitOne && lhs <= rhs)
				q = t;
		end
		mag = q;
		return (c < 0) ? 16'(-mag) : mag;
	endfunction

	function automatic vec_out_t normalize(vec_in_t v);
		vec_out_t    r;
		logic [33:0] s;
		s = 34'(int'(v.x_in) * int'(v.x_in)) + 34'(int'(v.y_in) * int'(v.y_in))
			+ 34'(int'(v.z_in) * int'(v.z_in));
		if (s == 0) begin
			r.unit_x = '0;
			r.unit_y = '0;
			r.unit_z = UnitOne;
			r.length_out = LenOne;
		end else begin
			r.unit_x = unit_component(v.x_in, s);
			r.unit_y = unit_component(v.y_in, s);
			r.unit_z = unit_component(v.z_in, s);
			r.length_out = length_floor(s);
		end
		return r;
	endfunction

	function automatic vec_out_t mk_res(int ux, int uy, int uz, int len);
		vec_out_t r;
		r.unit_x = 16'(ux);
		r.unit_y = 16'(uy);
		r.unit_z = 16'(uz);
		r.length_out = 16'(len);
		return r;
	endfunction

	function automatic row_t mk_row(int x, int y, int z, bit known = 1'b0,
			vec_out_t res = '0);
		row_t r;
		r.vec.x_in = 16'(x);
		r.vec.y_in = 16'(y);
		r.vec.z_in = 16'(z);
		r.known = known;
		r.res = res;
		return r;
	endfunction

	// drive one transaction, holding valid until accepted
	task automatic send_vector(vec_in_t v, bit known, vec_out_t res);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= v;
		expected_units.insert(expected_units.size(), known ? res : normalize(v));
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// random vector: mostly full range, some small, some axis-aligned or extreme
	function automatic vec_in_t random_vector();
		vec_in_t v;
		case ($urandom_range(9))
			0: begin
				v.x_in = 16'($urandom_range(15)) - 16'sd8;
				v.y_in = 16'($urandom_range(15)) - 16'sd8;
				v.z_in = 16'($urandom_range(15)) - 16'sd8;
			end
			1: begin
				v = '0;
				case ($urandom_range(2))
					0: v.x_in = 16'($urandom);
					1: v.y_in = 16'($urandom);
					default: v.z_in = 16'($urandom);
				endcase
			end
			2: begin
				v.x_in = $urandom_range(1) ? 16'h8000 : 16'h7fff;
				v.y_in = $urandom_range(1) ? 16'h8000 : 16'($urandom);
				v.z_in = $urandom_range(1) ? 16'h7fff : 16'($urandom);
			end
			default: v = 48'({$urandom, $urandom});
		endcase
		return v;
	endfunction

	// output side: random stall and compare against the oldest expectation
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		vec_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_units.size() == 0) begin
				$error("unexpected transaction %h", out_data);
				error_count++;
			end else begin
				want = expected_units.pop_front();
				if (out_data.unit_x !== want.unit_x) begin
					$error("unit_x exp %0d got %0d", want.unit_x, out_data.unit_x);
					error_count++;
				end
				if (out_data.unit_y !== want.unit_y) begin
					$error("unit_y exp %0d got %0d", want.unit_y, out_data.unit_y);
					error_count++;
				end
				if (out_data.unit_z !== want.unit_z) begin
					$error("unit_z exp %0d got %0d", want.unit_z, out_data.unit_z);
					error_count++;
				end
				if (out_data.length_out !== want.length_out) begin
					$error("length_out exp %0d got %0d", want.length_out,
						out_data.length_out);
					error_count++;
				end
			end
		end
	end

	initial begin
		row_t directed[$];
		directed = {directed, mk_row(0, 0, 0, 1'b1, mk_res(0, 0, 16384, 256))};
		directed = {directed, mk_row(256, 0, 0, 1'b1, mk_res(16384, 0, 0, 256))};
		directed = {directed, mk_row(0, -256, 0, 1'b1, mk_res(0, -16384, 0, 256))};
		directed = {directed, mk_row(0, 0, 32767, 1'b1, mk_res(0, 0, 16384, 32767))};
		directed = {directed, mk_row(-32768, 0, 0, 1'b1, mk_res(-16384, 0, 0, 32768))};
		directed = {directed, mk_row(0, 0, -32768, 1'b1, mk_res(0, 0, -16384, 32768))};
		directed = {directed, mk_row(0, 1, 0, 1'b1, mk_res(0, 16384, 0, 1))};
		directed = {directed, mk_row(0, 0, -1, 1'b1, mk_res(0, 0, -16384, 1))};
		directed = {directed, mk_row(-32768, -32768, -32768)};
		directed = {directed, mk_row(32767, 32767, 32767)};
		directed = {directed, mk_row(32767, -32768, 32767)};
		directed = {directed, mk_row(1, 1, 1)};
		directed = {directed, mk_row(-1, 1, -1)};
		directed = {directed, mk_row(768, 1024, 0)};
		directed = {directed, mk_row(-3, 4, 12)};
		directed = {directed, mk_row(16'h5555, 16'haaaa, 16'h00ff)};
		directed = {directed, mk_row(16'haaaa, 16'h5555, 16'hff00)};
		directed = {directed, mk_row(1, 32767, -32768)};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_vector(directed[i].vec, directed[i].known, directed[i].res);
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 57 : 0;
			recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 28 : 0;
			repeat (410)
				send_vector(random_vector(), 1'b0, '0);
		end
		in_valid <= 1'b0;
		sending_done = 1'b1;
	end

	// end of run: drain, then let the chain settle
	initial begin
		wait (sending_done);
		while (expected_units.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// timeout guard
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
